// ----- rtl/core/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the converter checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define TLM_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("converter assertion failed");

// Clocked assertion that is checked in every cycle.
`define TLM_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("converter assertion failed");

`endif

// ----- rtl/core/tlmu8_pkg.sv -----
// ---------------------------------------------------------------------------
// tlmu8_pkg
// Types and constants shared by the trie based UTF-8 converter.
// ---------------------------------------------------------------------------
package tlmu8_pkg;

    typedef struct packed {
        logic       is_load;
        logic [4:0] node;
        logic [7:0] key;
        logic [7:0] eout;
        logic [4:0] enext;
    } item_t;

    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_CONVERT = 1'b1;

    localparam logic REG_LINE_BREAK = 1'b0;
    localparam logic REG_SUBST      = 1'b1;

    localparam logic [1:0] LB_KEEP    = 2'd0;
    localparam logic [1:0] LB_TO_LF   = 2'd1;
    localparam logic [1:0] LB_TO_CR   = 2'd2;
    localparam logic [1:0] LB_TO_CRLF = 2'd3;

    localparam logic [7:0] SUBST_RESET = 8'd26;
    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] CHAR_LF     = 8'h0a;
    localparam logic [7:0] CHAR_CR     = 8'h0d;

    localparam logic [7:0] CONT_MASK  = 8'hc0;
    localparam logic [7:0] CONT_CODE  = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'he0;
    localparam logic [7:0] LEAD2_CODE = 8'hc0;
    localparam logic [7:0] LEAD3_MASK = 8'hf0;
    localparam logic [7:0] LEAD3_CODE = 8'he0;
    localparam logic [7:0] LEAD4_MASK = 8'hf8;
    localparam logic [7:0] LEAD4_CODE = 8'hf0;

endpackage

// ----- rtl/core/trie_longest_match_utf8_decoder_unit.sv -----
// ---------------------------------------------------------------------------
// trie_longest_match_utf8_decoder_unit
// UTF-8 to single-byte charset converter driven by a loadable byte trie.
// ---------------------------------------------------------------------------
// Input beats arrive on the s_axis channel: tuser low loads one trie entry,
// tuser high converts one stream byte. Converted bytes leave on m_axis, and
// tlast marks the final byte caused by one input beat; a beat may cause none.
// The two registers (line-break mode, substitute byte) sit on the APB port; the
// user must write them only while the converter is idle: the block does not check.
// After reset the trie store is cleared one entry per cycle; s_axis_tready
// stays low until the clear is done. A two-entry queue decouples intake from
// the trie walker, so beats are taken while the walker is busy. The walker
// pops each beat, and a load is written to the trie as it is popped. A stream
// byte goes through pop, byte check, lookup over the registered trie read,
// final check and end of beat, with an emit step when it yields bytes. A byte
// replayed after a failed match goes through byte check and lookup again and
// emits its bytes; a skipped continuation takes only a byte check. When
// m_axis_tready is low the output register holds its beat and the walker
// waits, then s_axis_tready drops.
// ---------------------------------------------------------------------------
module trie_longest_match_utf8_decoder_unit #(
    parameter int TRIE_NODES    = 32,
    parameter int MAX_MATCH_LEN = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // trie_node[4:0], byte_value[12:5], entry_output[20:13], entry_next[25:21]
    input  logic [31:0] s_axis_tdata,
    // action[0]
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_byte[7:0]
    output logic [7:0]  m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [1:0]       line_break_reg;
    logic [7:0]       subst_reg;
    logic             cfg_write;
    logic             clearing;
    logic             item_valid;
    logic             item_pop;
    tlmu8_pkg::item_t item;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_break_reg <= tlmu8_pkg::LB_KEEP;
            subst_reg      <= tlmu8_pkg::SUBST_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == tlmu8_pkg::REG_LINE_BREAK)
            begin
                line_break_reg <= pwdata[1:0];
            end
            else
            begin
                subst_reg <= pwdata[7:0];
            end
        end
    end

    assign prdata = (paddr[2] == tlmu8_pkg::REG_SUBST) ? {24'd0, subst_reg}
                                                        : {30'd0, line_break_reg};

    tlmu8_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_data    (s_axis_tdata),
        .in_kind    (s_axis_tuser),
        .clearing   (clearing),
        .item       (item),
        .item_valid (item_valid),
        .item_pop   (item_pop)
    );

    tlmu8_back #(
        .TRIE_NODES    (TRIE_NODES),
        .MAX_MATCH_LEN (MAX_MATCH_LEN)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .item            (item),
        .item_valid      (item_valid),
        .item_pop        (item_pop),
        .clearing        (clearing),
        .line_break_mode (line_break_reg),
        .substitute_byte (subst_reg),
        .out_ready       (m_axis_tready),
        .out_valid       (m_axis_tvalid),
        .out_byte        (m_axis_tdata),
        .out_last        (m_axis_tlast)
    );

endmodule

// ----- rtl/core/tlmu8_ram.sv -----
// ---------------------------------------------------------------------------
// tlmu8_ram
// Generic single write port RAM with one registered read port.
// ---------------------------------------------------------------------------
module tlmu8_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/tlmu8_front.sv -----
// ---------------------------------------------------------------------------
// tlmu8_front
// Accepts input beats, sorts them into loads and conversions, and queues them.
// ---------------------------------------------------------------------------
module tlmu8_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [31:0]         in_data,
    input  logic                in_kind,
    input  logic                clearing,
    output tlmu8_pkg::item_t    item,
    output logic                item_valid,
    input  logic                item_pop
);

    tlmu8_pkg::item_t entry_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             push;
    logic             pop;
    tlmu8_pkg::item_t in_item;

    always_comb
    begin
        in_item.is_load = (in_kind == tlmu8_pkg::ACT_LOAD);
        in_item.node    = in_data[4:0];
        in_item.key     = in_data[12:5];
        in_item.eout    = in_data[20:13];
        in_item.enext   = in_data[25:21];
    end

    assign in_ready   = (count_reg != 2'd2) && !clearing;
    assign push       = in_valid && in_ready;
    assign item_valid = (count_reg != 2'd0);
    assign pop        = item_pop && item_valid;
    assign item       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ----- rtl/core/tlmu8_back.sv -----
// ---------------------------------------------------------------------------
// tlmu8_back
// Walks the trie for queued bytes, rewinds on failed matches, emits results.
// ---------------------------------------------------------------------------
module tlmu8_back #(
    parameter int TRIE_NODES    = 32,
    parameter int MAX_MATCH_LEN = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  tlmu8_pkg::item_t item,
    input  logic             item_valid,
    output logic             item_pop,
    output logic             clearing,
    input  logic [1:0]       line_break_mode,
    input  logic [7:0]       substitute_byte,
    input  logic             out_ready,
    output logic             out_valid,
    output logic [7:0]       out_byte,
    output logic             out_last
);

    localparam int NODE_W = (TRIE_NODES > 1) ? $clog2(TRIE_NODES) : 1;
    localparam int ADDR_W = NODE_W + 8;
    localparam int DEPTH  = TRIE_NODES * 256;
    localparam int POS_W  = (MAX_MATCH_LEN > 1) ? $clog2(MAX_MATCH_LEN) : 1;
    localparam int CNT_W  = $clog2(MAX_MATCH_LEN + 1);
    localparam int SUM_W  = CNT_W + 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_LOOK,
        S_EMIT,
        S_FIN
    } state_t;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic [POS_W-1:0]  base_reg, base_next;
    logic [CNT_W-1:0]  qlen_reg, qlen_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [4:0]        node_reg, node_next;
    logic [7:0]        saved_out_reg, saved_out_next;
    logic [CNT_W-1:0]  saved_pos_reg, saved_pos_next;
    logic [7:0]        prev_reg, prev_next;
    logic [1:0]        skip_reg, skip_next;
    logic              hold_valid_reg, hold_valid_next;
    logic [1:0]        em_cnt_reg, em_cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_last_reg, out_last_next;
    logic [7:0]        out_byte_reg, out_byte_next;
    logic              node_ok_reg, node_ok_next;

    logic [7:0]        q_reg [MAX_MATCH_LEN];
    logic [7:0]        hold_byte_reg, hold_byte_next;
    logic [7:0]        em0_reg, em0_next;
    logic [7:0]        em1_reg, em1_next;
    logic [7:0]        cur_byte_reg, cur_byte_next;
    logic [7:0]        first_reg, first_next;
    logic              q_we;
    logic [POS_W-1:0]  q_waddr;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [12:0]       ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [12:0]       ram_rdata;

    logic              out_free;
    logic [7:0]        rd_byte;
    logic [12:0]       entry;
    logic [7:0]        ent_out;
    logic [4:0]        ent_next;
    logic [CNT_W-1:0]  cnt_new;
    logic              failed;
    logic [7:0]        sv_out;
    logic [CNT_W-1:0]  sv_pos;
    logic [7:0]        h;
    logic [1:0]        fb_cnt;
    logic [7:0]        fb0;
    logic [7:0]        fb1;
    logic [1:0]        fb_skip;
    logic [CNT_W-1:0]  drop;

    function automatic logic [POS_W-1:0] wrap_idx(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] lim;
        lim = SUM_W'(MAX_MATCH_LEN);
        if (s >= lim)
        begin
            return POS_W'(s - lim);
        end
        return POS_W'(s);
    endfunction

    assign out_free  = !out_valid_reg || out_ready;
    assign rd_byte   = q_reg[wrap_idx(SUM_W'(base_reg) + SUM_W'(pos_reg))];
    assign entry     = node_ok_reg ? ram_rdata : 13'd0;
    assign ent_out   = entry[12:5];
    assign ent_next  = entry[4:0];
    assign cnt_new   = pos_reg + CNT_W'(1);
    assign ram_raddr = {NODE_W'(node_reg), rd_byte};
    assign h         = (pos_reg == '0) ? cur_byte_reg : first_reg;

    always_comb
    begin
        fb_cnt  = 2'd1;
        fb0     = h;
        fb1     = tlmu8_pkg::CHAR_LF;
        fb_skip = 2'd0;
        if (!h[7])
        begin
            if (h == tlmu8_pkg::CHAR_NUL)
            begin
                fb0 = tlmu8_pkg::CHAR_NUL;
            end
            else if (h == tlmu8_pkg::CHAR_LF && prev_reg == tlmu8_pkg::CHAR_CR)
            begin
                fb_cnt = (line_break_mode == tlmu8_pkg::LB_KEEP) ? 2'd1 : 2'd0;
            end
            else
            begin
                case (line_break_mode)
                    tlmu8_pkg::LB_KEEP:  fb0 = h;
                    tlmu8_pkg::LB_TO_LF: fb0 = tlmu8_pkg::CHAR_LF;
                    tlmu8_pkg::LB_TO_CR: fb0 = tlmu8_pkg::CHAR_CR;
                    default:
                    begin
                        fb0    = tlmu8_pkg::CHAR_CR;
                        fb_cnt = 2'd2;
                    end
                endcase
            end
        end
        else
        begin
            fb0 = substitute_byte;
            if ((h & tlmu8_pkg::LEAD2_MASK) == tlmu8_pkg::LEAD2_CODE)
            begin
                fb_skip = 2'd1;
            end
            else if ((h & tlmu8_pkg::LEAD3_MASK) == tlmu8_pkg::LEAD3_CODE)
            begin
                fb_skip = 2'd2;
            end
            else if ((h & tlmu8_pkg::LEAD4_MASK) == tlmu8_pkg::LEAD4_CODE)
            begin
                fb_skip = 2'd3;
            end
        end
    end

    always_comb
    begin
        sv_out = saved_out_reg;
        sv_pos = saved_pos_reg;
        failed = 1'b0;
        if (ent_next == 5'd0)
        begin
            failed = (ent_out == 8'd0);
        end
        else
        begin
            if (ent_out != 8'd0)
            begin
                sv_out = ent_out;
                sv_pos = cnt_new;
            end
            failed = (cnt_new >= CNT_W'(MAX_MATCH_LEN));
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        base_next       = base_reg;
        qlen_next       = qlen_reg;
        pos_next        = pos_reg;
        node_next       = node_reg;
        saved_out_next  = saved_out_reg;
        saved_pos_next  = saved_pos_reg;
        prev_next       = prev_reg;
        skip_next       = skip_reg;
        hold_valid_next = hold_valid_reg;
        hold_byte_next  = hold_byte_reg;
        em_cnt_next     = em_cnt_reg;
        em0_next        = em0_reg;
        em1_next        = em1_reg;
        cur_byte_next   = cur_byte_reg;
        first_next      = first_reg;
        node_ok_next    = node_ok_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        item_pop        = 1'b0;
        q_we            = 1'b0;
        q_waddr         = wrap_idx(SUM_W'(base_reg) + SUM_W'(qlen_reg));
        ram_we          = 1'b0;
        ram_waddr       = {NODE_W'(item.node), item.key};
        ram_wdata       = {item.eout, item.enext};
        drop            = '0;

        case (state_reg)
            S_CLEAR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = 13'd0;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    item_pop = 1'b1;
                    if (item.is_load)
                    begin
                        ram_we = (32'(item.node) < TRIE_NODES);
                    end
                    else
                    begin
                        q_we       = 1'b1;
                        qlen_next  = qlen_reg + CNT_W'(1);
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (pos_reg == qlen_reg)
                begin
                    state_next = S_FIN;
                end
                else if (skip_reg != 2'd0
                         && (rd_byte & tlmu8_pkg::CONT_MASK) == tlmu8_pkg::CONT_CODE)
                begin
                    skip_next = skip_reg - 2'd1;
                    prev_next = rd_byte;
                    base_next = wrap_idx(SUM_W'(base_reg) + SUM_W'(1));
                    qlen_next = qlen_reg - CNT_W'(1);
                end
                else
                begin
                    skip_next     = 2'd0;
                    cur_byte_next = rd_byte;
                    node_ok_next  = (32'(node_reg) < TRIE_NODES);
                    state_next    = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (pos_reg == '0)
                begin
                    first_next = cur_byte_reg;
                end
                state_next = S_CHECK;
                if (failed)
                begin
                    if (sv_out != 8'd0)
                    begin
                        em_cnt_next = 2'd1;
                        em0_next    = sv_out;
                        drop        = sv_pos;
                        prev_next   = 8'd0;
                    end
                    else
                    begin
                        em_cnt_next = fb_cnt;
                        em0_next    = fb0;
                        em1_next    = fb1;
                        skip_next   = fb_skip;
                        drop        = CNT_W'(1);
                        prev_next   = h;
                    end
                    node_next      = 5'd0;
                    pos_next       = '0;
                    saved_out_next = 8'd0;
                    saved_pos_next = '0;
                    state_next     = S_EMIT;
                end
                else if (ent_next == 5'd0)
                begin
                    em_cnt_next    = 2'd1;
                    em0_next       = ent_out;
                    drop           = cnt_new;
                    prev_next      = cur_byte_reg;
                    node_next      = 5'd0;
                    pos_next       = '0;
                    saved_out_next = 8'd0;
                    saved_pos_next = '0;
                    state_next     = S_EMIT;
                end
                else
                begin
                    saved_out_next = sv_out;
                    saved_pos_next = sv_pos;
                    node_next      = ent_next;
                    pos_next       = cnt_new;
                end
                base_next = wrap_idx(SUM_W'(base_reg) + SUM_W'(drop));
                qlen_next = qlen_reg - drop;
            end
            S_EMIT:
            begin
                if (em_cnt_reg == 2'd0)
                begin
                    state_next = S_CHECK;
                end
                else if (!hold_valid_reg || out_free)
                begin
                    if (hold_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = hold_byte_reg;
                        out_last_next  = 1'b0;
                    end
                    hold_valid_next = 1'b1;
                    hold_byte_next  = em0_reg;
                    em0_next        = em1_reg;
                    em_cnt_next     = em_cnt_reg - 2'd1;
                end
            end
            S_FIN:
            begin
                if (!hold_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_byte_next   = hold_byte_reg;
                    out_last_next   = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            base_reg       <= '0;
            qlen_reg       <= '0;
            pos_reg        <= '0;
            node_reg       <= 5'd0;
            saved_out_reg  <= 8'd0;
            saved_pos_reg  <= '0;
            prev_reg       <= 8'd0;
            skip_reg       <= 2'd0;
            hold_valid_reg <= 1'b0;
            em_cnt_reg     <= 2'd0;
            node_ok_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
            out_byte_reg   <= 8'd0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            base_reg       <= base_next;
            qlen_reg       <= qlen_next;
            pos_reg        <= pos_next;
            node_reg       <= node_next;
            saved_out_reg  <= saved_out_next;
            saved_pos_reg  <= saved_pos_next;
            prev_reg       <= prev_next;
            skip_reg       <= skip_next;
            hold_valid_reg <= hold_valid_next;
            em_cnt_reg     <= em_cnt_next;
            node_ok_reg    <= node_ok_next;
            out_valid_reg  <= out_valid_next;
            out_last_reg   <= out_last_next;
            out_byte_reg   <= out_byte_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_byte_reg <= hold_byte_next;
        em0_reg       <= em0_next;
        em1_reg       <= em1_next;
        cur_byte_reg  <= cur_byte_next;
        first_reg     <= first_next;
        if (q_we)
        begin
            q_reg[q_waddr] <= item.key;
        end
    end

    tlmu8_ram #(
        .WIDTH (13),
        .DEPTH (DEPTH)
    ) u_trie_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign clearing  = (state_reg == S_CLEAR);
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

endmodule

// ----- rtl/core/tlmu8_checker.sv -----
// ---------------------------------------------------------------------------
// tlmu8_checker
// Port level checks for the converter, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tlmu8_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tlast
);

    `TLM_ASSERT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    `TLM_ASSERT(a_no_intake_after_reset, clk, rst_n, !$past(rst_n) |-> !s_axis_tready)
    `TLM_ASSERT(a_no_output_after_reset, clk, rst_n, !$past(rst_n) |-> !m_axis_tvalid)

endmodule

bind trie_longest_match_utf8_decoder_unit tlmu8_checker u_tlmu8_checker (.*);

// ----- tb/testbench.sv -----
// ---------------------------------------------------------------------------
// Trie converter testbench
// Loads byte tries over the input stream, converts directed and random UTF-8
// byte streams under every line-break mode and several substitute bytes, and
// compares each output beat with a behavioural model of the converter.
// ---------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tlmu8_pkg::*;

    localparam int NODES   = 32;
    localparam int MATCH_MAX = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    trie_longest_match_utf8_decoder_unit dut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

    // Model state.
    logic [1:0]  lb_mode;
    logic [7:0]  subst;
    logic [12:0] trie [NODES*256];
    logic [7:0]  rewind [MATCH_MAX];
    int unsigned cur_node, saved_out, saved_pos, buf_cnt, prev_byte, skip_cnt;

    logic [8:0]  exp_beats [$];
    int          mismatches = 0;
    int          burst_left = 0;
    int          gap_left = 0;

    task automatic push_byte(int unsigned v);
        exp_beats.push_back({1'b0, v[7:0]});
    endtask

    task automatic fallback_byte(int unsigned h);
        if (h[7] == 1'b0)
        begin
            if (h == CHAR_NUL)
                push_byte(0);
            else if (h == CHAR_LF && prev_byte == CHAR_CR)
            begin
                if (lb_mode == LB_KEEP)
                    push_byte(h);
            end
            else if (lb_mode == LB_KEEP)
                push_byte(h);
            else if (lb_mode == LB_TO_LF)
                push_byte(CHAR_LF);
            else if (lb_mode == LB_TO_CR)
                push_byte(CHAR_CR);
            else
            begin
                push_byte(CHAR_CR);
                push_byte(CHAR_LF);
            end
        end
        else
        begin
            if ((h & LEAD2_MASK) == LEAD2_CODE)
                skip_cnt = 1;
            else if ((h & LEAD3_MASK) == LEAD3_CODE)
                skip_cnt = 2;
            else if ((h & LEAD4_MASK) == LEAD4_CODE)
                skip_cnt = 3;
            else
                skip_cnt = 0;
            push_byte(subst);
        end
    endtask

    task automatic convert_byte(logic [7:0] in_byte);
        logic [7:0]  pend [$];
        logic [7:0]  nxt [$];
        int unsigned b, e, o, nx, drop, first_new;
        bit          failed;
        first_new = exp_beats.size();
        pend.push_back(in_byte);
        while (pend.size() > 0)
        begin
            b = pend.pop_front();
            if (skip_cnt > 0 && (b & CONT_MASK) == CONT_CODE)
            begin
                skip_cnt--;
                prev_byte = b;
                continue;
            end
            skip_cnt = 0;
            failed = 1'b0;
            if (buf_cnt < MATCH_MAX)
            begin
                rewind[buf_cnt] = b;
                buf_cnt++;
            end
            e = (cur_node < NODES) ? trie[cur_node*256 + b] : 0;
            o = (e >> 5) & 8'hff;
            nx = e & 5'h1f;
            if (nx == 0)
            begin
                if (o == 0)
                    failed = 1'b1;
                else
                begin
                    push_byte(o);
                    prev_byte = b;
                    cur_node = 0;
                    buf_cnt = 0;
                    saved_out = 0;
                    saved_pos = 0;
                end
            end
            else
            begin
                if (o != 0)
                begin
                    saved_out = o;
                    saved_pos = buf_cnt;
                end
                cur_node = nx;
                if (buf_cnt >= MATCH_MAX)
                    failed = 1'b1;
            end
            if (!failed)
                continue;
            cur_node = 0;
            if (saved_out != 0)
            begin
                push_byte(saved_out);
                drop = saved_pos;
                prev_byte = 0;
            end
            else
            begin
                fallback_byte(rewind[0]);
                prev_byte = rewind[0];
                drop = 1;
            end
            if (drop > buf_cnt)
                drop = buf_cnt;
            nxt.delete();
            for (int unsigned k = drop; k < buf_cnt; k++)
                nxt.push_back(rewind[k]);
            while (pend.size() > 0 && nxt.size() < 2*MATCH_MAX + 1)
                nxt.push_back(pend.pop_front());
            pend = nxt;
            buf_cnt = 0;
            saved_out = 0;
            saved_pos = 0;
        end
        if (exp_beats.size() > first_new)
            exp_beats[$][8] = 1'b1;
    endtask

    task automatic send_beat(logic act, logic [4:0] node, logic [7:0] key,
                             logic [7:0] eout, logic [4:0] enext);
        if (burst_left == 0)
        begin
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            burst_left = $urandom_range(1, 12);
        end
        if (gap_left != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap_left)
                @(posedge clk);
        end
        gap_left = 0;
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= act;
        s_axis_tdata <= {6'd0, enext, eout, key, node};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (act == ACT_LOAD)
            trie[{node, key}] = {eout, enext};
        else
            convert_byte(key);
    endtask

    task automatic load_entry(int node, int key, int eout, int enext);
        send_beat(ACT_LOAD, node[4:0], key[7:0], eout[7:0], enext[4:0]);
    endtask

    task automatic conv(int v);
        send_beat(ACT_CONVERT, 5'd0, v[7:0], 8'd0, 5'd0);
    endtask

    // Waits for the converter to drain, then writes one register.
    task automatic write_reg(logic idx, int unsigned value);
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (exp_beats.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (40)
            @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_LINE_BREAK)
            lb_mode = value[1:0];
        else
            subst = value[7:0];
    endtask

    // Receiver stall pattern and output checker.
    int stall_phase = 0;
    always @(posedge clk)
    begin
        logic [8:0] want;
        stall_phase <= stall_phase + 1;
        if (stall_phase % 160 < 60)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(0, 3) != 0);
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (exp_beats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: data %h last %b", m_axis_tdata, m_axis_tlast);
            end
            else
            begin
                want = exp_beats.pop_front();
                if (want != {m_axis_tlast, m_axis_tdata})
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("beat mismatch: expected %h last %b, got %h last %b",
                                 want[7:0], want[8], m_axis_tdata, m_axis_tlast);
                end
            end
        end
    end

    // A small trie: ASCII "ab"->0x80, "abc"->0x81 (longest match with
    // rewind), UTF-8 e2 82 ac -> 0xa4, c3 a9 -> 0xe9, a deep chain of 8 'z'.
    task automatic load_sample_trie();
        load_entry(0, "a", 0, 1);
        load_entry(1, "b", 8'h80, 2);
        load_entry(2, "c", 8'h81, 0);
        load_entry(0, 8'he2, 0, 3);
        load_entry(3, 8'h82, 0, 4);
        load_entry(4, 8'hac, 8'ha4, 0);
        load_entry(0, 8'hc3, 0, 5);
        load_entry(5, 8'ha9, 8'he9, 0);
        load_entry(0, 8'h7a, 0, 6);
        for (int i = 6; i < 13; i++)
            load_entry(i, 8'h7a, (i == 8) ? 8'h90 : 0, i + 1);
        load_entry(31, 8'hff, 8'hff, 31);
        load_entry(0, 8'hfe, 8'h55, 31);
    endtask

    task automatic test_directed();
        load_sample_trie();
        conv(8'h00); conv(8'h0d); conv(8'h0a); conv("a"); conv("b"); conv("c");
        conv("a"); conv("b"); conv("x"); conv(8'he2); conv(8'h82); conv(8'hac);
        conv(8'he2); conv(8'h41); conv(8'hf0); conv(8'h90); conv(8'h80);
        conv(8'h80); conv(8'h80); conv(8'hff); conv(8'hfe); conv(8'hff);
        for (int i = 0; i < 9; i++)
            conv(8'h7a);
        conv(8'h0a);
    endtask

    task automatic test_line_breaks();
        for (int m = 0; m < 4; m++)
        begin
            write_reg(REG_LINE_BREAK, m);
            write_reg(REG_SUBST, (m == 0) ? 0 : (m == 3) ? 255 : $urandom_range(0, 255));
            conv(8'h0d); conv(8'h0a); conv(8'h0a); conv(8'h20); conv(8'h7f);
            conv(8'hc3); conv(8'ha9); conv(8'hc3); conv(8'h0d); conv(8'ha9);
        end
    endtask

    task automatic test_random_stream(int count);
        int pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 6)
                load_entry($urandom_range(0, 31), $urandom_range(0, 255),
                           ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 255),
                           ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 31));
            else if (pick < 35)
            begin
                conv("a");
                if ($urandom_range(0, 3) != 0) conv("b");
                if ($urandom_range(0, 1) != 0) conv("c");
            end
            else if (pick < 50)
            begin
                conv(8'he2); conv(8'h82);
                if ($urandom_range(0, 3) != 0) conv(8'hac);
            end
            else if (pick < 60)
            begin
                conv(8'hc3); conv(8'h80 | $urandom_range(0, 63));
            end
            else if (pick < 70)
            begin
                conv($urandom_range(0, 1) ? 8'h0d : 8'h0a);
            end
            else if (pick < 78)
                for (int k = $urandom_range(1, 10); k > 0; k--)
                    conv(8'h7a);
            else
                conv($urandom_range(0, 255));
            if (i % 60 == 59)
            begin
                write_reg(REG_LINE_BREAK, $urandom_range(0, 3));
                write_reg(REG_SUBST, $urandom_range(0, 255));
            end
        end
    endtask

    initial
    begin
        int guard;
        lb_mode = LB_KEEP;
        subst = SUBST_RESET;
        for (int i = 0; i < NODES*256; i++)
            trie[i] = '0;
        for (int i = 0; i < MATCH_MAX; i++)
            rewind[i] = '0;
        cur_node = 0; saved_out = 0; saved_pos = 0;
        buf_cnt = 0; prev_byte = 0; skip_cnt = 0;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_line_breaks();
        test_random_stream(105);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        guard = 0;
        while (exp_beats.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (100)
            @(posedge clk);
        if (mismatches == 0 && exp_beats.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
